// ----- rtl/core/rcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants of the serial channel frame decoder.
// ----------------------------------------------------------------------------
package rcd_pkg;

  localparam int CH_W        = 11;
  localparam int STORE_DEPTH = 12;
  localparam int STICK_LANES = 4;
  localparam int AUX_BITS    = 8;
  localparam int AUX_BASE    = 4;
  localparam int CNT_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [CH_W-1:0]  CENTER          = 11'd1024;
  localparam logic [CH_W-1:0]  AUX_THR_RST     = 11'd1100;
  localparam logic [CNT_W-1:0] BIND_FRAMES_RST = 7'd120;
  localparam logic [CNT_W-1:0] COUNT_MAX       = 7'd127;

  // Scaling: q = floor((mag * SCALE_N + c) / SCALE_D), SCALE_N / SCALE_D = 0.14662756/147 * 2^14
  localparam int MAG_W     = 11;
  localparam int Q_W       = 15;
  localparam int Y_W       = 40;
  localparam int K1_W      = 25;
  localparam int P1_W      = 36;
  localparam int EST_SHIFT = 20;
  localparam int AXIS_W    = 16;
  localparam int THR_W     = 15;

  localparam longint unsigned SCALE_N_L = 64'd938416384;
  localparam longint unsigned SCALE_D_L = 64'd57421875;

  localparam logic [29:0]          SCALE_N     = 30'(SCALE_N_L);
  localparam logic [25:0]          SCALE_D     = 26'(SCALE_D_L);
  localparam logic [Y_W-1:0]       RND_HALF    = Y_W'(SCALE_D_L / 2);
  localparam logic [Y_W-1:0]       RND_CEIL    = Y_W'(SCALE_D_L - 1);
  localparam logic [K1_W-1:0]      EST_K1      = K1_W'((SCALE_N_L << EST_SHIFT) / SCALE_D_L);
  localparam logic [EST_SHIFT-1:0] EST_K0_HALF =
    EST_SHIFT'(((SCALE_D_L / 2) << EST_SHIFT) / SCALE_D_L);
  localparam logic [EST_SHIFT-1:0] EST_K0_CEIL =
    EST_SHIFT'(((SCALE_D_L - 1) << EST_SHIFT) / SCALE_D_L);

  localparam int ONE_Q14  = 16384;
  localparam int THR_BIAS = 16385;
  localparam int Q_MAX    = 16736;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUX_THRESHOLD = CFG_IDX_W'(0),
    CFG_BIND_FRAMES   = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef struct packed {
    logic [STICK_LANES-1:0][CH_W-1:0] stick;
    logic [AUX_BITS-1:0]              aux_bits;
    logic                             bind_mode;
    logic                             link_ready;
  } rcd_frame_t;

  typedef struct packed {
    logic [AUX_BITS-1:0] aux_bits;
    logic                bind_mode;
    logic                link_ready;
  } rcd_side_t;

  typedef struct packed {
    logic push;
  } rcd_push_ctl_t;

endpackage

// ----- rtl/core/rcd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_if
// Valid/ready channels of the decoder: channel word beats in, frame results out.
// ----------------------------------------------------------------------------
interface rcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] word_high;
  logic [7:0] word_low;
  logic       last;

  modport source (output valid, word_high, word_low, last, input ready);
  modport sink   (input valid, word_high, word_low, last, output ready);
endinterface

interface rcd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic signed [15:0] yaw;
  logic [14:0]        throttle;
  logic [7:0]         aux_bits;
  logic               bind_mode;
  logic               link_ready;

  modport source (output valid, roll, pitch, yaw, throttle, aux_bits, bind_mode, link_ready,
                  input ready);
  modport sink   (input valid, roll, pitch, yaw, throttle, aux_bits, bind_mode, link_ready,
                  output ready);
endinterface

// ----- rtl/core/rcd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_fifo
// Short frame queue between the word front end and the scaling back end.
// ----------------------------------------------------------------------------
module rcd_fifo import rcd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  rcd_push_ctl_t push_ctl_in,
  output logic          full,
  input  rcd_frame_t    push_data,
  input  logic          pop,
  output logic          avail,
  output rcd_frame_t    pop_data
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  rcd_frame_t       mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             do_push, do_pop;

  assign full     = (level_r == LVL_W'(FIFO_DEPTH));
  assign avail    = (level_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push_ctl_in.push && !full;
  assign do_pop   = pop && avail;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/rcd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_front
// Word unpack, channel store, frame tracking, bind counter and aux compare.
// ----------------------------------------------------------------------------
module rcd_front import rcd_pkg::*; #(
  parameter int NUM_CHANNELS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rcd_in_if.sink                in_ch,
  input  logic                  queue_full,
  output rcd_push_ctl_t         push_ctl,
  output rcd_frame_t            push_data
);

  localparam int LIVE_CH = (NUM_CHANNELS < STORE_DEPTH) ? NUM_CHANNELS : STORE_DEPTH;

  logic [CH_W-1:0]  store_r [LIVE_CH];
  logic [CH_W-1:0]  store_nxt [LIVE_CH];
  logic [CH_W-1:0]  view [STORE_DEPTH];
  logic [CH_W-1:0]  aux_thr_r;
  logic [CNT_W-1:0] bind_frames_r;
  logic [CNT_W-1:0] good_cnt_r, good_cnt_nxt;
  logic             frame_good_r, frame_good_nxt;
  logic             bind_flag_r, bind_flag_nxt;
  logic             ready_flag_r, ready_flag_nxt;
  logic             acc, hit, good_now, fire;
  logic [3:0]       ch;
  logic [CH_W-1:0]  val;
  logic [CNT_W:0]   inc;
  logic [CNT_W-1:0] n_sat;

  assign in_ch.ready = !queue_full;
  assign acc         = in_ch.valid && !queue_full;
  assign ch          = in_ch.word_high[6:3];
  assign val         = {in_ch.word_high[2:0], in_ch.word_low};
  assign hit         = ({1'b0, ch} < 5'(LIVE_CH));
  assign good_now    = frame_good_r || (acc && hit);
  assign fire        = acc && in_ch.last && good_now;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_view
    if (i < LIVE_CH) begin : g_live
      assign store_nxt[i] = (acc && hit && (ch == 4'(i))) ? val : store_r[i];
      assign view[i]      = store_nxt[i];
    end else begin : g_dead
      assign view[i] = '0;
    end
  end

  assign inc   = {1'b0, good_cnt_r} + (CNT_W + 1)'(1);
  assign n_sat = (inc > {1'b0, COUNT_MAX}) ? COUNT_MAX : inc[CNT_W-1:0];

  always_comb begin
    frame_good_nxt = fire ? 1'b0 : good_now;
    good_cnt_nxt   = good_cnt_r;
    bind_flag_nxt  = bind_flag_r;
    ready_flag_nxt = ready_flag_r;
    if (fire) begin
      good_cnt_nxt = n_sat;
      if (n_sat < bind_frames_r) begin
        bind_flag_nxt = 1'b1;
      end
      if (n_sat > bind_frames_r) begin
        ready_flag_nxt = 1'b1;
        bind_flag_nxt  = 1'b0;
        good_cnt_nxt   = bind_frames_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    push_ctl.push = fire;
    for (int l = 0; l < STICK_LANES; l++) begin
      push_data.stick[l] = view[l];
    end
    for (int a = 0; a < AUX_BITS; a++) begin
      push_data.aux_bits[a] = (view[a + AUX_BASE] > aux_thr_r);
    end
    push_data.bind_mode  = bind_flag_nxt;
    push_data.link_ready = ready_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aux_thr_r     <= AUX_THR_RST;
      bind_frames_r <= BIND_FRAMES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUX_THRESHOLD: aux_thr_r     <= cfg_wdata;
        CFG_BIND_FRAMES:   bind_frames_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_good_r <= 1'b0;
      good_cnt_r   <= '0;
      bind_flag_r  <= 1'b0;
      ready_flag_r <= 1'b0;
      for (int i = 0; i < LIVE_CH; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      frame_good_r <= frame_good_nxt;
      good_cnt_r   <= good_cnt_nxt;
      bind_flag_r  <= bind_flag_nxt;
      ready_flag_r <= ready_flag_nxt;
      for (int i = 0; i < LIVE_CH; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ready_flag_r |=> ready_flag_r)
    else $error("link ready flag dropped");

  a_frame_closed: assert property (@(posedge clk) disable iff (!rst_n)
    push_ctl.push |=> !frame_good_r)
    else $error("frame still marked good after its result");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    push_ctl.push |=> (good_cnt_r != '0))
    else $error("good frame count zero after a good frame");

endmodule

// ----- rtl/core/rcd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_back
// Scaling pipeline: estimate, remainder check, sign and clamp, output register.
// ----------------------------------------------------------------------------
module rcd_back import rcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       frame_avail,
  input  rcd_frame_t frame_data,
  output logic       frame_pop,
  rcd_out_if.source  out_ch
);

  logic advance;
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;

  rcd_side_t s1_side_r, s2_side_r, s3_side_r;

  logic [Y_W-1:0]       s1_y_r   [STICK_LANES];
  logic [P1_W-1:0]      s1_p1_r  [STICK_LANES];
  logic [EST_SHIFT-1:0] s1_k0_r  [STICK_LANES];
  logic                 s1_neg_r [STICK_LANES];
  logic [Y_W-1:0]       s2_y_r   [STICK_LANES];
  logic [Y_W-1:0]       s2_pe_r  [STICK_LANES];
  logic [Q_W-1:0]       s2_e_r   [STICK_LANES];
  logic                 s2_neg_r [STICK_LANES];
  logic [Q_W-1:0]       s3_q_r   [STICK_LANES];
  logic                 s3_neg_r [STICK_LANES];

  logic signed [AXIS_W-1:0] roll_r, pitch_r, yaw_r;
  logic [THR_W-1:0]         throttle_r;
  rcd_side_t                out_side_r;

  assign advance   = !out_valid_r || out_ch.ready;
  assign frame_pop = advance && frame_avail;

  for (genvar l = 0; l < STICK_LANES; l++) begin : g_lane
    logic [CH_W-1:0]      v;
    logic                 neg;
    logic [MAG_W-1:0]     mag;
    logic [Y_W-1:0]       y_c;
    logic [EST_SHIFT-1:0] k0;
    logic [P1_W:0]        est_sum;
    logic [Q_W-1:0]       e;
    logic [Y_W-1:0]       r;

    assign v   = frame_data.stick[l];
    assign neg = (v < CENTER);
    assign mag = neg ? (CENTER - v) : (v - CENTER);

    if (l == 0) begin : g_floor
      assign y_c = neg ? RND_CEIL : '0;
      assign k0  = neg ? EST_K0_CEIL : '0;
    end else begin : g_round
      assign y_c = RND_HALF;
      assign k0  = EST_K0_HALF;
    end

    assign est_sum = {1'b0, s1_p1_r[l]} + (P1_W + 1)'(s1_k0_r[l]);
    assign e       = est_sum[EST_SHIFT + Q_W - 1:EST_SHIFT];
    assign r       = s2_y_r[l] - s2_pe_r[l];

    always_ff @(posedge clk) begin
      if (advance) begin
        s1_y_r[l]   <= Y_W'(mag) * Y_W'(SCALE_N) + y_c;
        s1_p1_r[l]  <= P1_W'(mag) * P1_W'(EST_K1);
        s1_k0_r[l]  <= k0;
        s1_neg_r[l] <= neg;
        s2_y_r[l]   <= s1_y_r[l];
        s2_pe_r[l]  <= Y_W'(e) * Y_W'(SCALE_D);
        s2_e_r[l]   <= e;
        s2_neg_r[l] <= s1_neg_r[l];
        s3_q_r[l]   <= s2_e_r[l] + Q_W'(r >= Y_W'(SCALE_D));
        s3_neg_r[l] <= s2_neg_r[l];
      end
    end
  end

  function automatic logic signed [AXIS_W-1:0] axis_sign(input logic [Q_W-1:0] q,
                                                         input logic neg);
    logic [AXIS_W-1:0] m;
    m = AXIS_W'(q);
    return neg ? $signed(AXIS_W'(0) - m) : $signed(m);
  endfunction

  logic signed [Q_W+1:0] thr_sf;
  logic signed [Q_W+2:0] thr_t;
  logic signed [Q_W+2:0] thr_h;
  logic [THR_W-1:0]      thr_val;

  always_comb begin
    thr_sf = s3_neg_r[0] ? -$signed({2'b00, s3_q_r[0]}) : $signed({2'b00, s3_q_r[0]});
    thr_t  = {thr_sf[Q_W+1], thr_sf} + $signed((Q_W + 3)'(THR_BIAS));
    thr_h  = thr_t >>> 1;
    if (thr_h[Q_W+2]) begin
      thr_val = '0;
    end else if (thr_h[Q_W+1:0] > (Q_W + 2)'(ONE_Q14)) begin
      thr_val = THR_W'(ONE_Q14);
    end else begin
      thr_val = thr_h[THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_side_r  <= '{aux_bits: frame_data.aux_bits, bind_mode: frame_data.bind_mode,
                      link_ready: frame_data.link_ready};
      s2_side_r  <= s1_side_r;
      s3_side_r  <= s2_side_r;
      out_side_r <= s3_side_r;
      roll_r     <= axis_sign(s3_q_r[1], s3_neg_r[1]);
      pitch_r    <= axis_sign(s3_q_r[2], s3_neg_r[2]);
      yaw_r      <= axis_sign(s3_q_r[3], s3_neg_r[3]);
      throttle_r <= thr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= frame_pop;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.roll       = roll_r;
  assign out_ch.pitch      = pitch_r;
  assign out_ch.yaw        = yaw_r;
  assign out_ch.throttle   = throttle_r;
  assign out_ch.aux_bits   = out_side_r.aux_bits;
  assign out_ch.bind_mode  = out_side_r.bind_mode;
  assign out_ch.link_ready = out_side_r.link_ready;

  for (genvar l = 0; l < STICK_LANES; l++) begin : g_chk
    a_est_low: assert property (@(posedge clk) disable iff (!rst_n)
      s2_valid_r |-> (s2_y_r[l] >= s2_pe_r[l]))
      else $error("quotient estimate overshoots");

    a_est_close: assert property (@(posedge clk) disable iff (!rst_n)
      s2_valid_r |-> ((s2_y_r[l] - s2_pe_r[l]) < (Y_W'(SCALE_D) << 1)))
      else $error("quotient estimate short by more than one");

    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
      s3_valid_r |-> (s3_q_r[l] <= Q_W'(Q_MAX)))
      else $error("scaled magnitude out of range");
  end

endmodule

// ----- rtl/core/rc_serial_channel_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_serial_channel_frame_decoder
// Channel words of an 11-bit serial receiver frame in, one scaled result out
// per good frame.
// ----------------------------------------------------------------------------
// Takes one channel word beat per clock; in_ch.ready drops only while the
// two-entry frame queue is full, which happens only when out_ch is held off.
// The frame that a beat closes enters the queue on that beat's own edge,
// then passes three scaling stages and the sign and clamp stage into the
// output register. Results flow out one per clock while out_ch accepts
// them. The back end's scaling pipeline, four lanes of an estimate
// multiply, a remainder multiply and one correction, sets the latency.
// The user writes aux_threshold and bind_frames through cfg_we, cfg_index
// and cfg_wdata only while no frame is in flight; the block does not check.
module rc_serial_channel_frame_decoder import rcd_pkg::*; #(
  parameter int NUM_CHANNELS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rcd_in_if.sink                in_ch,
  rcd_out_if.source             out_ch
);

  rcd_push_ctl_t push_ctl;
  rcd_frame_t    push_data;
  rcd_frame_t    pop_data;
  logic          queue_full;
  logic          queue_avail;
  logic          queue_pop;

  rcd_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push_ctl   (push_ctl),
    .push_data  (push_data)
  );

  rcd_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_ctl_in (push_ctl),
    .full        (queue_full),
    .push_data   (push_data),
    .pop         (queue_pop),
    .avail       (queue_avail),
    .pop_data    (pop_data)
  );

  rcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_avail (queue_avail),
    .frame_data  (pop_data),
    .frame_pop   (queue_pop),
    .out_ch      (out_ch)
  );

endmodule

// ----- test/rcd_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_frame_checker
// Watches the channel word and frame result channels of the frame decoder,
// keeps its own copy of the channel store, bind counter and registers, works
// out the result of every good frame and compares each result beat with the
// oldest result still due.
// ----------------------------------------------------------------------------
module rcd_frame_checker import rcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_word_high,
  input  logic [7:0]            in_word_low,
  input  logic                  in_last,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic signed [15:0]    out_roll,
  input  logic signed [15:0]    out_pitch,
  input  logic signed [15:0]    out_yaw,
  input  logic [14:0]           out_throttle,
  input  logic [7:0]            out_aux_bits,
  input  logic                  out_bind_mode,
  input  logic                  out_link_ready,
  output int                    fail_count,
  output int                    pending
);

  localparam int          NUM_CH         = 12;
  localparam logic [10:0] THR_AT_RESET   = 11'd1100;
  localparam logic [6:0]  NEED_AT_RESET  = 7'd120;
  localparam int          TALLY_CEILING  = 127;
  localparam longint      GAIN_NUM       = 64'sd240234594304;
  localparam longint      GAIN_DEN       = 64'sd14700000000;
  localparam longint      MID_SCALE      = 64'sd1024;
  localparam longint      UNIT_Q14       = 64'sd16384;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic [14:0]        throttle;
    logic [7:0]         aux_bits;
    logic               bind_mode;
    logic               link_ready;
  } frame_result_t;

  frame_result_t results_due [$];
  frame_result_t due;

  logic [10:0] chan_val [NUM_CH];
  logic        frame_ok;
  logic [6:0]  frame_tally;
  logic        bind_q;
  logic        ready_q;
  logic [10:0] aux_thr;
  logic [6:0]  bind_need;
  logic [3:0]  word_ch;
  int          tally_next;
  longint      offs;
  longint      num;
  longint      thr_q;
  int          errs = 0;
  int          depth = 0;

  assign fail_count = errs;
  assign pending    = depth;

  function automatic logic signed [15:0] stick_q14(input logic [10:0] v);
    longint mag;
    longint q;
    mag = (v < 11'd1024) ? MID_SCALE - longint'(v) : longint'(v) - MID_SCALE;
    q = (mag * GAIN_NUM + GAIN_DEN / 2) / GAIN_DEN;
    if (v < 11'd1024) q = -q;
    return q[15:0];
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      errs++;
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) chan_val[i] = '0;
      frame_ok    = 1'b0;
      frame_tally = '0;
      bind_q      = 1'b0;
      ready_q     = 1'b0;
      aux_thr     = THR_AT_RESET;
      bind_need   = NEED_AT_RESET;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_AUX_THRESHOLD: aux_thr   = cfg_wdata[10:0];
          CFG_BIND_FRAMES:   bind_need = cfg_wdata[6:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          errs++;
          $display("%0t ns: result beat with none expected: roll %0d pitch %0d yaw %0d",
                   $time, out_roll, out_pitch, out_yaw);
        end else begin
          due = results_due.pop_front();
          check_field("roll", due.roll, out_roll);
          check_field("pitch", due.pitch, out_pitch);
          check_field("yaw", due.yaw, out_yaw);
          check_field("throttle", due.throttle, out_throttle);
          check_field("aux_bits", due.aux_bits, out_aux_bits);
          check_field("bind_mode", due.bind_mode, out_bind_mode);
          check_field("link_ready", due.link_ready, out_link_ready);
        end
      end

      if (in_valid && in_ready) begin
        word_ch = in_word_high[6:3];
        if (int'(word_ch) < NUM_CH) begin
          chan_val[word_ch] = {in_word_high[2:0], in_word_low};
          frame_ok = 1'b1;
        end
        if (in_last && frame_ok) begin
          frame_ok = 1'b0;

          tally_next = int'(frame_tally) + 1;
          if (tally_next > TALLY_CEILING) tally_next = TALLY_CEILING;
          if (tally_next < int'(bind_need)) bind_q = 1'b1;
          if (tally_next > int'(bind_need)) begin
            ready_q    = 1'b1;
            bind_q     = 1'b0;
            tally_next = int'(bind_need) + 1;
          end
          frame_tally = 7'(tally_next);

          due.roll  = stick_q14(chan_val[1]);
          due.pitch = stick_q14(chan_val[2]);
          due.yaw   = stick_q14(chan_val[3]);

          offs = longint'(chan_val[0]) - MID_SCALE;
          num  = offs * GAIN_NUM + UNIT_Q14 * GAIN_DEN;
          if (num <= 0) begin
            thr_q = 0;
          end else begin
            thr_q = (num + GAIN_DEN) / (2 * GAIN_DEN);
            if (thr_q > UNIT_Q14) thr_q = UNIT_Q14;
          end
          due.throttle = 15'(thr_q);

          for (int i = 0; i < 8; i++) due.aux_bits[i] = chan_val[i + 4] > aux_thr;
          due.bind_mode  = bind_q;
          due.link_ready = ready_q;
          results_due.push_back(due);
        end
      end
    end
    depth = results_due.size();
  end

endmodule

// ----- test/tb_rc_serial_channel_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_serial_channel_frame_decoder
// Drives channel word beats into the frame decoder with random gaps and
// output stalls: a directed opening on field extremes and special words,
// then phases of random frames and noise under changing register settings.
// A checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_rc_serial_channel_frame_decoder import rcd_pkg::*; ();

  localparam int PHASE_ITEMS = 92;
  localparam int SETTLE      = 20;
  localparam int IDLE_LIMIT  = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_AUX_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int          chk_fails;
  int          chk_pending;
  int          sent        = 0;
  int          idle_cycles = 0;
  int          in_streak   = 0;
  int          out_streak  = 0;
  logic [10:0] cur_thr     = 11'd1100;

  rcd_in_if  in_ch ();
  rcd_out_if out_ch ();

  always #1 clk = ~clk;

  rc_serial_channel_frame_decoder #(.NUM_CHANNELS(12)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  rcd_frame_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_word_high   (in_ch.word_high),
    .in_word_low    (in_ch.word_low),
    .in_last        (in_ch.last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_roll       (out_ch.roll),
    .out_pitch      (out_ch.pitch),
    .out_yaw        (out_ch.yaw),
    .out_throttle   (out_ch.throttle),
    .out_aux_bits   (out_ch.aux_bits),
    .out_bind_mode  (out_ch.bind_mode),
    .out_link_ready (out_ch.link_ready),
    .fail_count     (chk_fails),
    .pending        (chk_pending)
  );

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic pick_wait(inout int streak, output int gap);
    if (streak > 0) begin
      streak--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      streak = $urandom_range(8, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
    end
  endtask

  task automatic send_beat(input logic [7:0] hi, input logic [7:0] lo, input logic lst);
    int gap;
    pick_wait(in_streak, gap);
    while (gap > 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.word_high <= 8'($urandom);
      in_ch.word_low  <= 8'($urandom);
      in_ch.last      <= 1'($urandom);
      @(negedge clk);
      gap--;
    end
    in_ch.valid     <= 1'b1;
    in_ch.word_high <= hi;
    in_ch.word_low  <= lo;
    in_ch.last      <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_chan(input logic [3:0] ch, input logic [10:0] v, input logic lst);
    send_beat({1'($urandom_range(0, 1)), ch, v[10:8]}, v[7:0], lst);
  endtask

  function automatic logic [10:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 11'd0;
      1:       return 11'd2047;
      2:       return 11'(1023 + $urandom_range(0, 2));
      3:       return cur_thr + 11'($urandom_range(0, 2)) - 11'd1;
      default: return 11'($urandom);
    endcase
  endfunction

  task automatic random_items();
    int goal;
    int len;
    logic [3:0] ch;
    goal = sent + PHASE_ITEMS;
    while (sent < goal) begin
      if ($urandom_range(0, 4) == 0) begin
        send_beat(8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          ch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                           : 4'($urandom_range(0, 11));
          send_chan(ch, pick_value(), i == len - 1);
        end
      end
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [10:0] thr, input logic [6:0] need);
    wait_idle();
    cfg_write(CFG_AUX_THRESHOLD, thr);
    cfg_write(CFG_BIND_FRAMES, {4'd0, need});
    cur_thr = thr;
    random_items();
  endtask

  initial begin : sink_side
    int  hold;
    logic took;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      took = out_ch.valid && out_ch.ready;
      @(negedge clk);
      if (took) pick_wait(out_streak, hold);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.word_high = 8'd0;
    in_ch.word_low  = 8'd0;
    in_ch.last      = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // lone word on a fresh store, spare top bit set
    send_beat({1'b1, 4'd1, 3'b111}, 8'hFF, 1'b1);
    // frame of a single unused channel: no result
    send_chan(4'd13, 11'd1000, 1'b1);
    // full frame at the extremes, closed by an unused channel word
    send_chan(4'd0, 11'd2047, 1'b0);
    send_chan(4'd1, 11'd0, 1'b0);
    send_chan(4'd2, 11'd1024, 1'b0);
    send_chan(4'd3, 11'd1023, 1'b0);
    send_chan(4'd4, 11'd2047, 1'b0);
    send_chan(4'd5, 11'd0, 1'b0);
    send_chan(4'd6, 11'd1101, 1'b0);
    send_chan(4'd7, 11'd1100, 1'b0);
    send_chan(4'd8, 11'd1099, 1'b0);
    send_chan(4'd9, 11'd1, 1'b0);
    send_chan(4'd10, 11'd1025, 1'b0);
    send_chan(4'd11, 11'd1500, 1'b0);
    send_beat(8'hFF, 8'hFF, 1'b1);
    // throttle below center, stray channel in the middle
    send_chan(4'd0, 11'd0, 1'b0);
    send_chan(4'd12, 11'd2047, 1'b0);
    send_chan(4'd3, 11'd1025, 1'b0);
    send_chan(4'd2, 11'd2047, 1'b1);
    send_chan(4'd0, 11'd1, 1'b0);
    send_beat({1'b0, 4'd14, 3'b000}, 8'h00, 1'b1);

    random_items();
    run_phase(11'd0, 7'd127);
    run_phase(11'd2047, 7'd10);
    run_phase(11'($urandom), 7'd0);
    run_phase(11'($urandom), 7'd120);
    run_phase(11'($urandom), 7'd1);
    run_phase(11'd1024, 7'($urandom));
    run_phase(11'($urandom), 7'd127);

    wait_idle();
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rcd_pkg.sv
rtl/core/rcd_if.sv
rtl/core/rcd_fifo.sv
rtl/core/rcd_front.sv
rtl/core/rcd_back.sv
rtl/core/rc_serial_channel_frame_decoder.sv
test/rcd_frame_checker.sv
test/tb_rc_serial_channel_frame_decoder.sv
